// File: hw/rtl/usb_control_endpoint_sequencer_macros.svh
// Assertion macros shared by the control endpoint sequencer RTL
`ifndef USB_CONTROL_ENDPOINT_SEQUENCER_MACROS_SVH
`define USB_CONTROL_ENDPOINT_SEQUENCER_MACROS_SVH

`ifndef SYNTHESIS

// Check that an implication holds at every clock edge outside reset
`define UCES_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never becomes true outside reset
`define UCES_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define UCES_ASSERT(lbl, prop, msg)

`define UCES_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

// File: hw/rtl/usb_ep0_pkg.sv
// Types, codes and setup decode for the control endpoint sequencer
`timescale 1ns / 1ps

package usb_ep0_pkg;

  // Divider sweep: one quotient bit per cycle over a 16-bit length
  localparam int unsigned DivSteps = 16;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  localparam logic [6:0] MaxPktReset = 7'd64;
  localparam logic [6:0] MaxPktLow   = 7'd8;
  localparam logic [6:0] MaxPktHigh  = 7'd64;

  // bmRequestType fields
  localparam logic [7:0] ReqTypeMask = 8'h60;
  localparam logic [4:0] RcptDevice  = 5'd0;
  localparam logic [4:0] RcptIface   = 5'd1;
  localparam logic [4:0] RcptEndpt   = 5'd2;

  // Standard request codes
  localparam logic [7:0] ReqGetStatus  = 8'd0;
  localparam logic [7:0] ReqSetAddress = 8'd5;
  localparam logic [7:0] ReqGetDesc    = 8'd6;
  localparam logic [7:0] ReqGetConfig  = 8'd8;
  localparam logic [7:0] ReqSetConfig  = 8'd9;
  localparam logic [7:0] ReqSynchFrame = 8'd12;

  localparam logic [15:0] StatusLen = 16'd2;
  localparam logic [15:0] ConfigLen = 16'd1;

  typedef enum logic [1:0] {
    OP_SETUP     = 2'd0,
    OP_IN_DONE   = 2'd1,
    OP_OUT_DONE  = 2'd2,
    OP_BUS_RESET = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_TX    = 2'd1,
    ACT_RX    = 2'd2,
    ACT_STALL = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    SRC_NONE = 2'd0,
    SRC_ZERO = 2'd1,
    SRC_DESC = 2'd2,
    SRC_CONF = 2'd3
  } source_e;

  typedef enum logic [2:0] {
    PH_WAIT_SETUP  = 3'd0,
    PH_TX          = 3'd1,
    PH_RX          = 3'd2,
    PH_WAIT_STATUS = 3'd3,
    PH_SEND_STATUS = 3'd4,
    PH_ERROR       = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_DECODE,
    FSM_DIVIDE,
    FSM_RESOLVE
  } fsm_e;

  typedef struct packed {
    logic        ok;
    source_e     src;
    logic [15:0] len;
    logic        addr_wr;
    logic [6:0]  addr;
    logic        cfg_wr;
  } setup_dec_t;

  // Result packed from the lowest bit up: action first
  typedef struct packed {
    logic [2:0]  pad;
    phase_e      control_state;
    logic [7:0]  current_configuration;
    logic [6:0]  device_address;
    logic        address_write;
    logic [13:0] packet_count;
    logic [15:0] transfer_length;
    source_e     data_source;
    action_e     action;
  } result_t;

  // Decode a standard setup request by recipient and code
  function automatic setup_dec_t decode_setup(logic [7:0] rtype, logic [7:0] code,
                                              logic [15:0] value, logic [15:0] dlen);
    setup_dec_t d;
    d = '0;
    d.src = SRC_NONE;
    if ((rtype & ReqTypeMask) == 8'h00) begin
      case (rtype[4:0])
        RcptDevice: begin
          case (code)
            ReqGetStatus: begin
              d.src = SRC_ZERO;
              d.len = StatusLen;
              d.ok  = 1'b1;
            end
            ReqSetAddress: begin
              d.addr_wr = 1'b1;
              d.addr    = value[6:0];
              d.ok      = 1'b1;
            end
            ReqGetDesc: begin
              d.src = SRC_DESC;
              d.len = dlen;
              d.ok  = (dlen != 16'd0);
            end
            ReqGetConfig: begin
              d.src = SRC_CONF;
              d.len = ConfigLen;
              d.ok  = 1'b1;
            end
            ReqSetConfig: begin
              d.cfg_wr = 1'b1;
              d.ok     = 1'b1;
            end
            default: d.ok = 1'b0;
          endcase
        end
        RcptIface: begin
          if (code == ReqGetStatus) begin
            d.src = SRC_ZERO;
            d.len = StatusLen;
            d.ok  = 1'b1;
          end
        end
        RcptEndpt: begin
          if (code == ReqSynchFrame) begin
            d.src = SRC_ZERO;
            d.len = StatusLen;
            d.ok  = 1'b1;
          end
        end
        default: d.ok = 1'b0;
      endcase
    end
    return d;
  endfunction

endpackage

// File: hw/rtl/usb_control_endpoint_sequencer.sv
// Endpoint 0 control transfer sequencer with a shared bit-serial divider
`timescale 1ns / 1ps
`include "usb_control_endpoint_sequencer_macros.svh"

// Takes one endpoint 0 event per transfer (setup, IN complete, OUT complete,
// bus reset; the kind rides on s_axis_tuser_i) and returns exactly one result
// per event: the action to start, its data source, the length trimmed to
// wLength, the packet count, any address update, the held configuration and
// the control phase. The result register is loaded after decode and trim, the
// restoring divider (one quotient bit per cycle, by the clamped max packet
// size), and resolving the new state. s_axis_tready_o rises again with the
// load, so a new event is taken only once the sequencer is through with the
// last one; the resolve cycle is held for as long as an earlier result still
// waits on the output side. The divider gives both the packet count and the
// zero-length-packet remainder check. A new event is taken while a result
// still waits on the output side.
// The user must write ep0_max_packet through the cfg channel only while the
// block is idle; the block itself does not enforce it. Values below 8 act as 8
// and above 64 act as 64.
module usb_control_endpoint_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: ep0_max_packet
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [6:0]  cfg_data_i,
  // Event input
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [7:0] request_type, [15:8] request_code, [31:16] request_value,
  // [47:32] request_length, [63:48] descriptor_length
  input  logic [63:0] s_axis_tdata_i,
  // [1:0] op
  input  logic [1:0]  s_axis_tuser_i,
  // Result output
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [1:0] action, [3:2] data_source, [19:4] transfer_length,
  // [33:20] packet_count, [34] address_write, [41:35] device_address,
  // [49:42] current_configuration, [52:50] control_state, [55:53] zero
  output logic [55:0] m_axis_tdata_o
);

  usb_ep0_pkg::fsm_e   fsm_q, fsm_d;
  usb_ep0_pkg::phase_e phase_q, phase_d;
  usb_ep0_pkg::op_e    op_q;

  logic [6:0]  eff_max_q;
  logic [7:0]  rtype_q, code_q;
  logic [15:0] value_q, wlen_q, dlen_q;
  logic [15:0] len_q, len_d;
  logic [15:0] quo_q, quo_d;
  logic [6:0]  rem_q, rem_d;
  logic [usb_ep0_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic [7:0]  config_q, config_d;
  logic [15:0] last_tx_q, last_tx_d;
  logic [15:0] last_req_q, last_req_d;
  logic        tx_busy_q, tx_busy_d;
  logic        rx_busy_q, rx_busy_d;
  logic        zlp_q, zlp_d;
  logic        out_valid_q, out_valid_d;
  usb_ep0_pkg::result_t out_q, out_d;

  usb_ep0_pkg::setup_dec_t dec;
  logic        in_xfer;
  logic        out_free;
  logic [7:0]  trial;
  logic        trial_ge;
  logic [7:0]  trial_diff;
  logic [13:0] pkt_calc;
  logic        dir_in;

  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (fsm_q == usb_ep0_pkg::FSM_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

  // Decode the captured setup fields
  assign dec    = usb_ep0_pkg::decode_setup(rtype_q, code_q, value_q, dlen_q);
  assign dir_in = rtype_q[7];

  // One restoring divide step by the clamped max packet size
  assign trial      = {rem_q, quo_q[15]};
  assign trial_ge   = (trial >= {1'b0, eff_max_q});
  assign trial_diff = trial - {1'b0, eff_max_q};

  // Packet count: ceiling of length over max packet, one for zero length
  assign pkt_calc = (len_q == 16'd0) ? 14'd1 : (quo_q[13:0] + {13'd0, (rem_q != 7'd0)});

  // Hold the clamped max packet size
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_max_q <= usb_ep0_pkg::MaxPktReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_data_i < usb_ep0_pkg::MaxPktLow) begin
        eff_max_q <= usb_ep0_pkg::MaxPktLow;
      end else if (cfg_data_i > usb_ep0_pkg::MaxPktHigh) begin
        eff_max_q <= usb_ep0_pkg::MaxPktHigh;
      end else begin
        eff_max_q <= cfg_data_i;
      end
    end
  end

  // Capture the event payload on transfer
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q    <= usb_ep0_pkg::op_e'(s_axis_tuser_i);
      rtype_q <= s_axis_tdata_i[7:0];
      code_q  <= s_axis_tdata_i[15:8];
      value_q <= s_axis_tdata_i[31:16];
      wlen_q  <= s_axis_tdata_i[47:32];
      dlen_q  <= s_axis_tdata_i[63:48];
    end
  end

  // Datapath registers without reset
  always_ff @(posedge clk_i) begin
    len_q <= len_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    out_q <= out_d;
  end

  // Control and endpoint state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q       <= usb_ep0_pkg::FSM_IDLE;
      phase_q     <= usb_ep0_pkg::PH_WAIT_SETUP;
      cnt_q       <= '0;
      config_q    <= '0;
      last_tx_q   <= '0;
      last_req_q  <= '0;
      tx_busy_q   <= 1'b0;
      rx_busy_q   <= 1'b0;
      zlp_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fsm_q       <= fsm_d;
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      config_q    <= config_d;
      last_tx_q   <= last_tx_d;
      last_req_q  <= last_req_d;
      tx_busy_q   <= tx_busy_d;
      rx_busy_q   <= rx_busy_d;
      zlp_q       <= zlp_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Sequence the event: decode, divide, resolve
  always_comb begin
    fsm_d       = fsm_q;
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    len_d       = len_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    config_d    = config_q;
    last_tx_d   = last_tx_q;
    last_req_d  = last_req_q;
    tx_busy_d   = tx_busy_q;
    rx_busy_d   = rx_busy_q;
    zlp_d       = zlp_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;

    case (fsm_q)
      usb_ep0_pkg::FSM_IDLE: begin
        if (in_xfer) begin
          fsm_d = usb_ep0_pkg::FSM_DECODE;
        end
      end

      usb_ep0_pkg::FSM_DECODE: begin
        // Trim setup length; in-complete divides the last transmit size
        if (op_q == usb_ep0_pkg::OP_SETUP) begin
          len_d = (dec.len > wlen_q) ? wlen_q : dec.len;
        end else begin
          len_d = last_tx_q;
        end
        quo_d = len_d;
        rem_d = '0;
        cnt_d = '0;
        fsm_d = usb_ep0_pkg::FSM_DIVIDE;
      end

      usb_ep0_pkg::FSM_DIVIDE: begin
        rem_d = trial_ge ? trial_diff[6:0] : trial[6:0];
        quo_d = {quo_q[14:0], trial_ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == usb_ep0_pkg::DivCntW'(usb_ep0_pkg::DivSteps - 1)) begin
          fsm_d = usb_ep0_pkg::FSM_RESOLVE;
        end
      end

      usb_ep0_pkg::FSM_RESOLVE: begin
        if (out_free) begin
          fsm_d       = usb_ep0_pkg::FSM_IDLE;
          out_valid_d = 1'b1;
          out_d       = '0;
          out_d.action      = usb_ep0_pkg::ACT_NONE;
          out_d.data_source = usb_ep0_pkg::SRC_NONE;
          case (op_q)
            usb_ep0_pkg::OP_SETUP: begin
              zlp_d      = 1'b0;
              last_req_d = wlen_q;
              if (!dec.ok) begin
                phase_d      = usb_ep0_pkg::PH_ERROR;
                out_d.action = usb_ep0_pkg::ACT_STALL;
              end else begin
                out_d.address_write  = dec.addr_wr;
                out_d.device_address = dec.addr;
                if (dec.cfg_wr) begin
                  config_d = value_q[7:0];
                end
                if (dir_in && (len_q != 16'd0)) begin
                  phase_d = usb_ep0_pkg::PH_TX;
                  if (!tx_busy_q) begin
                    last_tx_d             = len_q;
                    tx_busy_d             = 1'b1;
                    out_d.action          = usb_ep0_pkg::ACT_TX;
                    out_d.data_source     = dec.src;
                    out_d.transfer_length = len_q;
                    out_d.packet_count    = pkt_calc;
                  end
                end else if (dir_in) begin
                  phase_d = usb_ep0_pkg::PH_WAIT_STATUS;
                  if (!rx_busy_q) begin
                    rx_busy_d          = 1'b1;
                    out_d.action       = usb_ep0_pkg::ACT_RX;
                    out_d.packet_count = 14'd1;
                  end
                end else if (len_q != 16'd0) begin
                  phase_d = usb_ep0_pkg::PH_RX;
                  if (!rx_busy_q) begin
                    rx_busy_d             = 1'b1;
                    out_d.action          = usb_ep0_pkg::ACT_RX;
                    out_d.transfer_length = len_q;
                    out_d.packet_count    = pkt_calc;
                  end
                end else begin
                  phase_d = usb_ep0_pkg::PH_SEND_STATUS;
                  if (!tx_busy_q) begin
                    last_tx_d          = '0;
                    tx_busy_d          = 1'b1;
                    out_d.action       = usb_ep0_pkg::ACT_TX;
                    out_d.packet_count = 14'd1;
                  end
                end
              end
            end

            usb_ep0_pkg::OP_IN_DONE: begin
              tx_busy_d = 1'b0;
              if (phase_q == usb_ep0_pkg::PH_TX) begin
                if (!zlp_q && (last_tx_q < last_req_q) && (rem_q == 7'd0)) begin
                  // Close a short reply that ended on a packet boundary
                  zlp_d              = 1'b1;
                  last_tx_d          = '0;
                  tx_busy_d          = 1'b1;
                  out_d.action       = usb_ep0_pkg::ACT_TX;
                  out_d.packet_count = 14'd1;
                end else begin
                  phase_d = usb_ep0_pkg::PH_WAIT_STATUS;
                  if (!rx_busy_q) begin
                    rx_busy_d          = 1'b1;
                    out_d.action       = usb_ep0_pkg::ACT_RX;
                    out_d.packet_count = 14'd1;
                  end
                end
              end else if (phase_q == usb_ep0_pkg::PH_SEND_STATUS) begin
                phase_d = usb_ep0_pkg::PH_WAIT_SETUP;
              end else begin
                phase_d      = usb_ep0_pkg::PH_ERROR;
                out_d.action = usb_ep0_pkg::ACT_STALL;
              end
            end

            usb_ep0_pkg::OP_OUT_DONE: begin
              rx_busy_d = 1'b0;
              if (phase_q == usb_ep0_pkg::PH_WAIT_STATUS) begin
                phase_d = usb_ep0_pkg::PH_WAIT_SETUP;
              end else if (phase_q == usb_ep0_pkg::PH_RX) begin
                phase_d = usb_ep0_pkg::PH_SEND_STATUS;
                if (!tx_busy_q) begin
                  last_tx_d          = '0;
                  tx_busy_d          = 1'b1;
                  out_d.action       = usb_ep0_pkg::ACT_TX;
                  out_d.packet_count = 14'd1;
                end
              end
            end

            default: begin
              // Bus reset: drop transfers, apply address zero
              phase_d             = usb_ep0_pkg::PH_WAIT_SETUP;
              tx_busy_d           = 1'b0;
              rx_busy_d           = 1'b0;
              zlp_d               = 1'b0;
              out_d.address_write = 1'b1;
            end
          endcase
          out_d.current_configuration = config_d;
          out_d.control_state         = phase_d;
        end
      end

      default: fsm_d = usb_ep0_pkg::FSM_IDLE;
    endcase
  end

  `UCES_ASSERT(a_accept_to_decode, in_xfer |=> (fsm_q == usb_ep0_pkg::FSM_DECODE), "accepted event did not enter decode")
  `UCES_ASSERT(a_divide_done, ((fsm_q == usb_ep0_pkg::FSM_DIVIDE) && (cnt_q == usb_ep0_pkg::DivCntW'(usb_ep0_pkg::DivSteps - 1))) |=> (fsm_q == usb_ep0_pkg::FSM_RESOLVE), "divider did not finish after its last step")
  `UCES_ASSERT(a_rem_bound, (fsm_q == usb_ep0_pkg::FSM_RESOLVE) |-> (rem_q < eff_max_q), "divider remainder not below max packet")
  `UCES_ASSERT(a_stall_no_len, (out_valid_q && (out_q.action == usb_ep0_pkg::ACT_STALL)) |-> ((out_q.transfer_length == 16'd0) && (out_q.packet_count == 14'd0)), "stall result carries a length")
  `UCES_ASSERT(a_tx_sets_busy, ((fsm_q == usb_ep0_pkg::FSM_RESOLVE) && out_free && (out_d.action == usb_ep0_pkg::ACT_TX)) |=> tx_busy_q, "transmit start left endpoint idle")

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the endpoint 0 control transfer sequencer
`timescale 1ns / 1ps

module testbench;
  import usb_ep0_pkg::*;

  // One event as it goes onto the input stream, with an optional pinned result
  typedef struct {
    op_e         op;
    logic [7:0]  rtype;
    logic [7:0]  code;
    logic [15:0] value;
    logic [15:0] wlen;
    logic [15:0] dlen;
    bit          pinned;
    result_t     want;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni          = 1'b0;
  logic        cfg_valid_i     = 1'b0;
  logic        cfg_ready_o;
  logic [6:0]  cfg_data_i      = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  // [7:0] request_type, [15:8] request_code, [31:16] request_value,
  // [47:32] request_length, [63:48] descriptor_length
  logic [63:0] s_axis_tdata_i  = '0;
  // [1:0] op
  logic [1:0]  s_axis_tuser_i  = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  // [1:0] action, [3:2] data_source, [19:4] transfer_length,
  // [33:20] packet_count, [34] address_write, [41:35] device_address,
  // [49:42] current_configuration, [52:50] control_state, [55:53] zero
  logic [55:0] m_axis_tdata_o;

  usb_control_endpoint_sequencer uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  // Sequencer state as the testbench tracks it
  logic [6:0]  max_pkt_reg  = MaxPktReset;
  phase_e      ep0_phase    = PH_WAIT_SETUP;
  logic [7:0]  held_config  = '0;
  logic [15:0] last_tx_len  = '0;
  logic [15:0] last_wlen    = '0;
  bit          tx_busy      = 1'b0;
  bit          rx_busy      = 1'b0;
  bit          zlp_done     = 1'b0;

  result_t     awaited_results[$];
  int unsigned mismatch_count = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned sink_stall_pct = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  // Packet size in force: register clamped to the legal range
  function automatic int unsigned eff_max_packet();
    if (max_pkt_reg < MaxPktLow) return 32'(MaxPktLow);
    if (max_pkt_reg > MaxPktHigh) return 32'(MaxPktHigh);
    return 32'(max_pkt_reg);
  endfunction

  function automatic logic [13:0] packets_for(logic [15:0] len);
    int unsigned m;
    m = eff_max_packet();
    if (len == 16'd0) return 14'd1;
    return 14'((32'(len) + m - 1) / m);
  endfunction

  function automatic void launch_tx(source_e src, logic [15:0] len, inout result_t r);
    if (tx_busy) return;
    last_tx_len       = len;
    tx_busy           = 1'b1;
    r.action          = ACT_TX;
    r.data_source     = src;
    r.transfer_length = len;
    r.packet_count    = packets_for(len);
  endfunction

  function automatic void launch_rx(logic [15:0] len, inout result_t r);
    if (rx_busy) return;
    rx_busy           = 1'b1;
    r.action          = ACT_RX;
    r.data_source     = SRC_NONE;
    r.transfer_length = len;
    r.packet_count    = packets_for(len);
  endfunction

  // Advance the tracked state by one event and return the result it causes
  function automatic result_t next_ep0_result(stim_row_t ev);
    result_t     r;
    source_e     src;
    logic [15:0] len;
    bit          ok;
    r   = '0;
    src = SRC_NONE;
    len = '0;
    ok  = 1'b0;
    case (ev.op)
      OP_SETUP: begin
        ep0_phase = PH_WAIT_SETUP;
        zlp_done  = 1'b0;
        last_wlen = ev.wlen;
        // standard requests only
        if ((ev.rtype & ReqTypeMask) == 8'h00) begin
          if (ev.rtype[4:0] == RcptDevice) begin
            if (ev.code == ReqGetStatus) begin
              src = SRC_ZERO;
              len = StatusLen;
              ok  = 1'b1;
            end else if (ev.code == ReqSetAddress) begin
              r.address_write  = 1'b1;
              r.device_address = ev.value[6:0];
              ok               = 1'b1;
            end else if (ev.code == ReqGetDesc) begin
              src = SRC_DESC;
              len = ev.dlen;
              ok  = (ev.dlen != 16'd0);
            end else if (ev.code == ReqGetConfig) begin
              src = SRC_CONF;
              len = ConfigLen;
              ok  = 1'b1;
            end else if (ev.code == ReqSetConfig) begin
              held_config = ev.value[7:0];
              ok          = 1'b1;
            end
          end else if (ev.rtype[4:0] == RcptIface && ev.code == ReqGetStatus) begin
            src = SRC_ZERO;
            len = StatusLen;
            ok  = 1'b1;
          end else if (ev.rtype[4:0] == RcptEndpt && ev.code == ReqSynchFrame) begin
            src = SRC_ZERO;
            len = StatusLen;
            ok  = 1'b1;
          end
        end
        if (!ok) begin
          r.address_write  = 1'b0;
          r.device_address = '0;
          ep0_phase        = PH_ERROR;
          r.action         = ACT_STALL;
        end else begin
          if (len > ev.wlen) len = ev.wlen;
          if (ev.rtype[7]) begin
            if (len != 16'd0) begin
              ep0_phase = PH_TX;
              launch_tx(src, len, r);
            end else begin
              ep0_phase = PH_WAIT_STATUS;
              launch_rx(16'd0, r);
            end
          end else begin
            if (len != 16'd0) begin
              ep0_phase = PH_RX;
              launch_rx(len, r);
            end else begin
              ep0_phase = PH_SEND_STATUS;
              launch_tx(SRC_NONE, 16'd0, r);
            end
          end
        end
      end
      OP_IN_DONE: begin
        tx_busy = 1'b0;
        if (ep0_phase == PH_TX) begin
          // short reply on a packet boundary: one zero-length packet first
          if (!zlp_done && last_tx_len < last_wlen &&
              (32'(last_tx_len) % eff_max_packet()) == 0) begin
            zlp_done = 1'b1;
            launch_tx(SRC_NONE, 16'd0, r);
          end else begin
            ep0_phase = PH_WAIT_STATUS;
            launch_rx(16'd0, r);
          end
        end else if (ep0_phase == PH_SEND_STATUS) begin
          ep0_phase = PH_WAIT_SETUP;
        end else begin
          ep0_phase = PH_ERROR;
          r.action  = ACT_STALL;
        end
      end
      OP_OUT_DONE: begin
        rx_busy = 1'b0;
        if (ep0_phase == PH_WAIT_STATUS) begin
          ep0_phase = PH_WAIT_SETUP;
        end else if (ep0_phase == PH_RX) begin
          ep0_phase = PH_SEND_STATUS;
          launch_tx(SRC_NONE, 16'd0, r);
        end
      end
      default: begin
        ep0_phase       = PH_WAIT_SETUP;
        tx_busy         = 1'b0;
        rx_busy         = 1'b0;
        zlp_done        = 1'b0;
        r.address_write = 1'b1;
      end
    endcase
    r.current_configuration = held_config;
    r.control_state         = ep0_phase;
    return r;
  endfunction

  function automatic stim_row_t req_row(op_e op, logic [7:0] rtype, logic [7:0] code,
                                        logic [15:0] value, logic [15:0] wlen,
                                        logic [15:0] dlen);
    stim_row_t s;
    s.op     = op;
    s.rtype  = rtype;
    s.code   = code;
    s.value  = value;
    s.wlen   = wlen;
    s.dlen   = dlen;
    s.pinned = 1'b0;
    s.want   = '0;
    return s;
  endfunction

  function automatic stim_row_t with_result(stim_row_t s, result_t want);
    s.pinned = 1'b1;
    s.want   = want;
    return s;
  endfunction

  function automatic result_t result_of(action_e act, source_e src, logic [15:0] len,
                                        logic [13:0] cnt, logic aw, logic [6:0] addr,
                                        logic [7:0] conf, phase_e st);
    result_t r;
    r                       = '0;
    r.action                = act;
    r.data_source           = src;
    r.transfer_length       = len;
    r.packet_count          = cnt;
    r.address_write         = aw;
    r.device_address        = addr;
    r.current_configuration = conf;
    r.control_state         = st;
    return r;
  endfunction

  // Drive one event, hold it until the transfer, then queue its result
  task automatic send_event(stim_row_t ev);
    result_t r;
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {ev.dlen, ev.wlen, ev.value, ev.code, ev.rtype};
    s_axis_tuser_i  <= ev.op;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    r = next_ep0_result(ev);
    awaited_results.push_back(ev.pinned ? ev.want : r);
  endtask

  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_max_packet(logic [6:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    max_pkt_reg = v;
  endtask

  // Mostly well-formed standard requests, some with lengths on packet boundaries
  function automatic stim_row_t pick_request();
    stim_row_t   s;
    int unsigned m;
    int unsigned kind;
    m    = eff_max_packet();
    kind = $urandom_range(9);
    s    = req_row(OP_SETUP, 8'h80, ReqGetStatus, 16'($urandom),
                   16'($urandom_range(300)), 16'($urandom_range(300)));
    case (kind)
      0: s.rtype = 8'h80;
      1: s.rtype = 8'h81;
      2: begin
        s.rtype = 8'h82;
        s.code  = ReqSynchFrame;
      end
      3: begin
        s.rtype = 8'h00;
        s.code  = ReqSetAddress;
        s.wlen  = '0;
      end
      4: begin
        s.rtype = 8'h00;
        s.code  = ReqSetConfig;
        s.wlen  = '0;
      end
      5: s.code = ReqGetConfig;
      6, 7: begin
        s.code = ReqGetDesc;
        if ($urandom_range(1) == 0) begin
          s.dlen = 16'(m * $urandom_range(4));
          s.wlen = 16'(32'(s.dlen) + $urandom_range(2) * $urandom_range(3 * m));
        end
      end
      default: begin
        s.rtype = 8'($urandom);
        s.code  = ($urandom_range(1) == 0) ? 8'($urandom_range(13)) : 8'($urandom);
        s.wlen  = 16'($urandom);
        s.dlen  = 16'($urandom);
      end
    endcase
    if ($urandom_range(7) == 0) s.rtype[7] = ~s.rtype[7];
    if ($urandom_range(15) == 0) begin
      s.wlen = 16'($urandom);
      s.dlen = 16'($urandom);
    end
    return s;
  endfunction

  // Follow the control flow the host would drive, with some noise mixed in
  task automatic run_random(int unsigned count);
    stim_row_t s;
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(99) < 12) begin
        s = req_row(op_e'($urandom_range(3)), 8'($urandom), 8'($urandom),
                    16'($urandom), 16'($urandom), 16'($urandom));
      end else begin
        case (ep0_phase)
          PH_TX, PH_SEND_STATUS: s = req_row(OP_IN_DONE, '0, '0, '0, '0, '0);
          PH_RX, PH_WAIT_STATUS: s = req_row(OP_OUT_DONE, '0, '0, '0, '0, '0);
          default:               s = pick_request();
        endcase
      end
      send_event(s);
    end
  endtask

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // Receiver back-pressure
  always @(posedge clk_i) begin
    m_axis_tready_i <= rst_ni && ($urandom_range(99) >= sink_stall_pct);
  end

  // Compare each result transfer with the oldest queued expectation
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = result_t'(m_axis_tdata_o);
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $time, m_axis_tdata_o);
        mismatch_count++;
      end else begin
        want = awaited_results.pop_front();
        check_field("action", 32'(want.action), 32'(got.action));
        check_field("data_source", 32'(want.data_source), 32'(got.data_source));
        check_field("transfer_length", 32'(want.transfer_length), 32'(got.transfer_length));
        check_field("packet_count", 32'(want.packet_count), 32'(got.packet_count));
        check_field("address_write", 32'(want.address_write), 32'(got.address_write));
        check_field("device_address", 32'(want.device_address), 32'(got.device_address));
        check_field("current_configuration", 32'(want.current_configuration),
                    32'(got.current_configuration));
        check_field("control_state", 32'(want.control_state), 32'(got.control_state));
        check_field("pad", 32'(want.pad), 32'(got.pad));
      end
    end
  end

  stim_row_t   directed_rows[$];
  int unsigned phase_max[6]  = '{8, 127, 0, 37, 64, 0};
  int unsigned phase_src[6]  = '{0, 85, 0, 38, 0, 38};
  int unsigned phase_sink[6] = '{0, 0, 85, 38, 0, 38};
  int unsigned phase_len[6]  = '{130, 120, 120, 120, 70, 70};

  initial begin
    directed_rows = '{
      // IN completion with nothing pending stalls
      with_result(req_row(OP_IN_DONE, '0, '0, '0, '0, '0),
                  result_of(ACT_STALL, SRC_NONE, 0, 0, 0, 0, 8'h00, PH_ERROR)),
      with_result(req_row(OP_BUS_RESET, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF),
                  result_of(ACT_NONE, SRC_NONE, 0, 0, 1, 0, 8'h00, PH_WAIT_SETUP)),
      with_result(req_row(OP_SETUP, 8'h80, ReqGetStatus, '0, 16'd2, '0),
                  result_of(ACT_TX, SRC_ZERO, 2, 1, 0, 0, 8'h00, PH_TX)),
      with_result(req_row(OP_IN_DONE, '0, '0, '0, '0, '0),
                  result_of(ACT_RX, SRC_NONE, 0, 1, 0, 0, 8'h00, PH_WAIT_STATUS)),
      with_result(req_row(OP_OUT_DONE, '0, '0, '0, '0, '0),
                  result_of(ACT_NONE, SRC_NONE, 0, 0, 0, 0, 8'h00, PH_WAIT_SETUP)),
      // set address with every value bit high
      with_result(req_row(OP_SETUP, 8'h00, ReqSetAddress, 16'hFFFF, '0, 16'hFFFF),
                  result_of(ACT_TX, SRC_NONE, 0, 1, 1, 7'h7F, 8'h00, PH_SEND_STATUS)),
      with_result(req_row(OP_IN_DONE, '0, '0, '0, '0, '0),
                  result_of(ACT_NONE, SRC_NONE, 0, 0, 0, 0, 8'h00, PH_WAIT_SETUP)),
      req_row(OP_SETUP, 8'h00, ReqSetConfig, 16'h0AB5, '0, '0),
      req_row(OP_IN_DONE, '0, '0, '0, '0, '0),
      req_row(OP_SETUP, 8'h80, ReqGetConfig, '0, 16'hFFFF, '0),
      req_row(OP_IN_DONE, '0, '0, '0, '0, '0),
      req_row(OP_OUT_DONE, '0, '0, '0, '0, '0),
      // short reply on a packet boundary takes a zero-length packet
      req_row(OP_SETUP, 8'h80, ReqGetDesc, 16'h0100, 16'hFFFF, 16'd128),
      req_row(OP_IN_DONE, '0, '0, '0, '0, '0),
      req_row(OP_IN_DONE, '0, '0, '0, '0, '0),
      req_row(OP_OUT_DONE, '0, '0, '0, '0, '0),
      // missing descriptor stalls
      with_result(req_row(OP_SETUP, 8'h80, ReqGetDesc, 16'h0300, 16'd64, '0),
                  result_of(ACT_STALL, SRC_NONE, 0, 0, 0, 0, 8'hB5, PH_ERROR)),
      req_row(OP_SETUP, 8'h80, ReqGetDesc, 16'h0200, 16'hFFFF, 16'hFFFF),
      // transmit still busy: request dropped, phase moves anyway
      req_row(OP_SETUP, 8'h81, ReqGetStatus, '0, 16'd2, '0),
      with_result(req_row(OP_BUS_RESET, '0, '0, '0, '0, '0),
                  result_of(ACT_NONE, SRC_NONE, 0, 0, 1, 0, 8'hB5, PH_WAIT_SETUP)),
      req_row(OP_SETUP, 8'h82, ReqSynchFrame, '0, 16'd2, '0),
      req_row(OP_OUT_DONE, '0, '0, '0, '0, '0),
      // vendor type and unknown code stall
      with_result(req_row(OP_SETUP, 8'hC0, ReqGetStatus, '0, 16'd2, '0),
                  result_of(ACT_STALL, SRC_NONE, 0, 0, 0, 0, 8'hB5, PH_ERROR)),
      with_result(req_row(OP_SETUP, 8'h00, 8'hFF, '0, '0, '0),
                  result_of(ACT_STALL, SRC_NONE, 0, 0, 0, 0, 8'hB5, PH_ERROR)),
      // host-to-device data stage, status blocked by busy transmit
      req_row(OP_SETUP, 8'h00, ReqGetStatus, '0, 16'd2, '0),
      req_row(OP_OUT_DONE, '0, '0, '0, '0, '0),
      req_row(OP_IN_DONE, '0, '0, '0, '0, '0)
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) send_event(directed_rows[i]);
    drain_results();

    // Walk packet sizes and idle patterns, register written only when drained
    for (int p = 0; p < 6; p++) begin
      write_max_packet((p == 5) ? 7'($urandom_range(127)) : 7'(phase_max[p]));
      sender_idle_pct = phase_src[p];
      sink_stall_pct  = phase_sink[p];
      run_random(phase_len[p]);
      drain_results();
    end

    repeat (30) @(posedge clk_i);
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/usb_ep0_pkg.sv
hw/rtl/usb_control_endpoint_sequencer.sv
tb/testbench.sv
